/* src/lrupr_pkg.sv */
// lrupr_pkg: shared types and constants for the lru page replacement core
// no dependencies; imported by the cell, the top level, the checker and the testbench
package lrupr_pkg;

    localparam int PAGE_NUM_W   = 16;
    localparam int FAULT_W      = 32;
    localparam int CFG_W        = 4;
    localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd4;
    localparam logic [FAULT_W-1:0] FAULT_MAX  = {FAULT_W{1'b1}};

    // handed from one cell to the next along the stack
    typedef struct packed {
        logic valid;   // slot holds a page
        logic pass;    // no match seen in the cells above
    } lrupr_link_t;

endpackage

/* src/lrupr_cell.sv */
// lrupr_cell: one slot of the lru stack, holds a page and its valid bit
// depends on lrupr_pkg; loads from its upper neighbor while no hit is seen above
module lrupr_cell import lrupr_pkg::*; #(
    parameter int PAGE_BITS = 16,
    parameter int LIM_W     = 4,
    parameter int IDX       = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [PAGE_BITS-1:0] key,
    input  logic [LIM_W-1:0]     limit,
    input  logic [PAGE_BITS-1:0] prev_page,
    input  lrupr_link_t          link_in,
    output logic [PAGE_BITS-1:0] page_out,
    output lrupr_link_t          link_out,
    output logic [PAGE_BITS-1:0] last_page,
    output logic                 last_valid
);

    localparam logic [LIM_W-1:0] IDX_C  = LIM_W'(IDX);
    localparam logic [LIM_W-1:0] NEXT_C = LIM_W'(IDX + 1);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 valid_reg, valid_next;
    logic                 in_range, is_last, match;

    assign in_range = IDX_C < limit;
    assign is_last  = NEXT_C == limit;
    assign match    = valid_reg & in_range & (page_reg == key);

    assign link_out.valid = valid_reg & in_range;
    assign link_out.pass  = link_in.pass & ~match;
    assign page_out       = page_reg;
    assign last_page      = is_last ? page_reg : '0;
    assign last_valid     = is_last & valid_reg;

    always_comb begin
        valid_next = valid_reg;
        page_next  = page_reg;
        if (step) begin
            if (!in_range) begin
                valid_next = 1'b0;
            end else if (link_in.pass) begin
                valid_next = link_in.valid;
                page_next  = prev_page;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
    end

endmodule

/* src/lru_page_replacement_core.sv */
// lru_page_replacement_core: usage
// s_ channel takes one page reference per beat (s_page_number), m_ channel
// returns one result beat per reference: page_fault, evicted_valid,
// evicted_page and the saturating total_faults count.
// cfg channel writes frames_in_use (0 acts as 1, above MAX_FRAMES acts as
// MAX_FRAMES); write it only while no reference is in flight.
// the stack is a chain of MAX_FRAMES cells, slot 0 most recent; each cell
// compares its page with the reference and loads its upper neighbor while
// no hit lies above it, so the whole stack updates in the accept cycle.
// the result register raises m_valid in the cycle after the s_ beat is accepted.
// throughput: one reference per cycle while m_ready takes each result, set by the cell chain.
// a stalled m_ready holds the result; s_ready is high while the result
// register is empty or being taken in the same cycle.
// reset: all slots invalid, fault count zero, frames_in_use 4; no clear pass.
module lru_page_replacement_core import lrupr_pkg::*; #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PAGE_NUM_W-1:0] s_page_number,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_page_fault,
    output logic                  m_evicted_valid,
    output logic [PAGE_NUM_W-1:0] m_evicted_page,
    output logic [FAULT_W-1:0]    m_total_faults
);

    localparam int LIM_W0 = $clog2(MAX_FRAMES + 1);
    localparam int LIM_W  = (LIM_W0 > CFG_W) ? LIM_W0 : CFG_W;
    localparam logic [LIM_W-1:0] MAX_C = LIM_W'(MAX_FRAMES);
    localparam logic [LIM_W-1:0] ONE_C = LIM_W'(1);

    logic [CFG_W-1:0]      frames_reg;
    logic [LIM_W-1:0]      cfg_ext, limit;
    logic [PAGE_BITS-1:0]  key;
    logic                  step;

    logic [PAGE_BITS-1:0]  page_q [MAX_FRAMES+1];
    lrupr_link_t           link_q [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0]  tap_page [MAX_FRAMES];
    logic                  tap_valid [MAX_FRAMES];

    logic [PAGE_BITS-1:0]  ev_page;
    logic                  full, miss;

    logic                  m_valid_reg;
    logic                  fault_reg, ev_valid_reg;
    logic [PAGE_NUM_W-1:0] ev_page_reg;
    logic [FAULT_W-1:0]    count_reg, count_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign step      = s_valid & s_ready;
    assign key       = PAGE_BITS'(s_page_number);

    assign cfg_ext = LIM_W'(frames_reg);
    always_comb begin
        if (frames_reg == '0) begin
            limit = ONE_C;
        end else if (cfg_ext > MAX_C) begin
            limit = MAX_C;
        end else begin
            limit = cfg_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= FRAMES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frames_reg <= cfg_data;
        end
    end

    // slot 0 loads the new reference on every accepted beat
    assign page_q[0]       = key;
    assign link_q[0].valid = 1'b1;
    assign link_q[0].pass  = 1'b1;

    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        lrupr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .LIM_W     (LIM_W),
            .IDX       (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step       (step),
            .key        (key),
            .limit      (limit),
            .prev_page  (page_q[i]),
            .link_in    (link_q[i]),
            .page_out   (page_q[i+1]),
            .link_out   (link_q[i+1]),
            .last_page  (tap_page[i]),
            .last_valid (tap_valid[i])
        );
    end

    always_comb begin
        ev_page = '0;
        full    = 1'b0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            ev_page = ev_page | tap_page[i];
            full    = full | tap_valid[i];
        end
    end

    assign miss = link_q[MAX_FRAMES].pass;

    always_comb begin
        count_next = count_reg;
        if (miss && count_reg != FAULT_MAX) begin
            count_next = count_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (step) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            fault_reg    <= miss;
            ev_valid_reg <= miss & full;
            ev_page_reg  <= (miss && full) ? PAGE_NUM_W'(ev_page) : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_page_fault    = fault_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_page  = ev_page_reg;
    assign m_total_faults  = count_reg;

endmodule

/* src/lrupr_checker.sv */
// lrupr_checker: port-level assertions for lru_page_replacement_core
// depends on lrupr_pkg; attached to the top level by the bind at the end
module lrupr_checker import lrupr_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_W-1:0]      cfg_data,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [PAGE_NUM_W-1:0] s_page_number,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_page_fault,
    input logic                  m_evicted_valid,
    input logic [PAGE_NUM_W-1:0] m_evicted_page,
    input logic [FAULT_W-1:0]    m_total_faults
);

    // an eviction only happens on a fault
    a_evict_needs_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_valid |-> m_page_fault)
        else $error("eviction reported on a hit");

    // no eviction means a zero evicted page
    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_faults)
            && $stable(m_page_fault) && $stable(m_evicted_page))
        else $error("result beat changed while stalled");

    // consecutive beats step the fault count by this beat's fault, saturating
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |->
            m_total_faults == (($past(m_total_faults) == FAULT_MAX) ? FAULT_MAX :
                $past(m_total_faults) + FAULT_W'(m_page_fault)))
        else $error("fault count stepped wrong");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for lru_page_replacement_core
// depends on lrupr_pkg and the core; mirrors the lru stack to check every m_ beat
module tb_top;
    import lrupr_pkg::*;

    localparam int MAX_FRAMES  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic                  page_fault;
        logic                  evicted_valid;
        logic [PAGE_NUM_W-1:0] evicted_page;
        logic [FAULT_W-1:0]    total_faults;
    } lookup_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [PAGE_NUM_W-1:0] s_page_number;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_page_fault;
    logic                  m_evicted_valid;
    logic [PAGE_NUM_W-1:0] m_evicted_page;
    logic [FAULT_W-1:0]    m_total_faults;

    logic [PAGE_NUM_W-1:0] frame_page [MAX_FRAMES];
    logic                  frame_held [MAX_FRAMES];
    logic [FAULT_W-1:0]    fault_total;
    logic [CFG_W-1:0]      frames_reg;
    lookup_t               lookup_results [$];

    int idle_pct;
    bit hold_req;
    int hold_left;
    int err_count;
    int cycles;

    lru_page_replacement_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_NUM_W)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_page_fault    (m_page_fault),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_total_faults  (m_total_faults)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void push_down(input int last);
        for (int i = last; i > 0; i--) begin
            frame_page[i] = frame_page[i-1];
            frame_held[i] = frame_held[i-1];
        end
    endfunction

    function automatic lookup_t lru_lookup(input logic [PAGE_NUM_W-1:0] page);
        int      limit;
        int      count;
        int      hit_pos;
        bit      hit;
        lookup_t r;
        limit = (frames_reg == 0) ? 1 :
                (frames_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_reg);
        // slots past a lowered frame count vanish without an eviction
        for (int i = limit; i < MAX_FRAMES; i++) begin
            frame_held[i] = 1'b0;
            frame_page[i] = '0;
        end
        count = 0;
        while (count < limit && frame_held[count])
            count++;
        hit = 1'b0;
        hit_pos = 0;
        for (int i = 0; i < count; i++) begin
            if (!hit && frame_page[i] == page) begin
                hit = 1'b1;
                hit_pos = i;
            end
        end
        r = '0;
        if (hit) begin
            push_down(hit_pos);
        end else begin
            if (fault_total != FAULT_MAX)
                fault_total++;
            if (count >= limit) begin
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_page[limit-1];
                push_down(limit - 1);
            end else begin
                push_down(count);
            end
        end
        frame_page[0] = page;
        frame_held[0] = 1'b1;
        r.page_fault = !hit;
        r.total_faults = fault_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (err_count < 40)
            $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        err_count++;
    endtask

    task automatic touch_page(input logic [PAGE_NUM_W-1:0] page);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        lookup_results.insert(lookup_results.size(), lru_lookup(page));
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        frames_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_all_resolved;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lookup_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lookup_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 0, 1);
            end else begin
                want = lookup_results.pop_front();
                if (m_page_fault !== want.page_fault)
                    report_mismatch("page_fault", want.page_fault, m_page_fault);
                if (m_evicted_valid !== want.evicted_valid)
                    report_mismatch("evicted_valid", want.evicted_valid, m_evicted_valid);
                if (m_evicted_page !== want.evicted_page)
                    report_mismatch("evicted_page", want.evicted_page, m_evicted_page);
                if (m_total_faults !== want.total_faults)
                    report_mismatch("total_faults", want.total_faults, m_total_faults);
            end
        end
    end

    task automatic test_cold_fill;
        touch_page(16'h0000);
        touch_page(16'hFFFF);
        touch_page(16'h5555);
        touch_page(16'hAAAA);
        touch_page(16'h0000);
        touch_page(16'h0000);
        touch_page(16'h1234);
        touch_page(16'h5555);
        wait_all_resolved;
    endtask

    task automatic test_frame_bounds;
        // zero frames behaves as one
        set_frames(4'd0);
        touch_page(16'h0007);
        touch_page(16'h0007);
        touch_page(16'h0008);
        wait_all_resolved;
        // above the built count clamps to eight
        set_frames(4'd15);
        for (int i = 0; i < 9; i++)
            touch_page(PAGE_NUM_W'(16'h0100 + i));
        wait_all_resolved;
    endtask

    task automatic test_frame_shrink;
        set_frames(4'd2);
        touch_page(16'h0108);
        touch_page(16'h0100);
        wait_all_resolved;
    endtask

    task automatic test_output_stall;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            touch_page(PAGE_NUM_W'($urandom_range(0, 7)));
        wait_all_resolved;
    endtask

    task automatic test_random_traffic;
        logic [CFG_W-1:0]      settings [8] = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd5, 4'd0, 4'd4, 4'd7};
        logic [PAGE_NUM_W-1:0] pool [12];
        int                    pool_size;
        foreach (settings[p]) begin
            wait_all_resolved;
            idle_pct = (p == 1) ? 0 : 16;
            set_frames(settings[p]);
            pool_size = $urandom_range(1, 12);
            foreach (pool[k])
                pool[k] = PAGE_NUM_W'($urandom_range(0, 65535));
            repeat (80) begin
                if ($urandom_range(99) < 15)
                    touch_page(PAGE_NUM_W'($urandom_range(0, 65535)));
                else
                    touch_page(pool[$urandom_range(0, pool_size - 1)]);
            end
        end
        idle_pct = 16;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_page_number = '0;
        m_ready = 1'b0;
        idle_pct = 16;
        hold_req = 1'b0;
        hold_left = 0;
        err_count = 0;
        cycles = 0;
        frames_reg = FRAMES_RESET;
        fault_total = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_page[i] = '0;
            frame_held[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_cold_fill;
        test_frame_bounds;
        test_frame_shrink;
        test_output_stall;
        test_random_traffic;
        wait_all_resolved;
        repeat (4) @(posedge aclk);
        if (err_count == 0 && lookup_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
